### rtl/fsp_pkg.sv
// Shared constants for the focus step planner: widths, register map,
// reset values of the configuration registers and step codes.
// No dependencies.
package fsp_pkg;

  localparam int POSITION_BITS   = 14;
  localparam int DEFAULT_MAX_MOVES = 16;
  localparam int NUM_STEPS       = 6;
  localparam int STEP_IDX_W      = 3;
  localparam int CODE_W          = 4;
  localparam int APB_ADDR_W      = 5;
  localparam int APB_DATA_W      = 32;
  localparam int REG_IDX_W       = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_STEP_DIST_1  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEP_DIST_2  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_DIST_3  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_DIST_4  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEP_DIST_5  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEP_DIST_6  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FULL_TRAVEL  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ALWAYS_FAR   = 3'd7;

  // Reset values
  localparam logic [POSITION_BITS-1:0] RST_STEP_DIST_1 = 14'd38;
  localparam logic [POSITION_BITS-1:0] RST_STEP_DIST_2 = 14'd96;
  localparam logic [POSITION_BITS-1:0] RST_STEP_DIST_3 = 14'd244;
  localparam logic [POSITION_BITS-1:0] RST_STEP_DIST_4 = 14'd617;
  localparam logic [POSITION_BITS-1:0] RST_STEP_DIST_5 = 14'd1562;
  localparam logic [POSITION_BITS-1:0] RST_STEP_DIST_6 = 14'd3952;
  localparam logic [POSITION_BITS-1:0] RST_FULL_TRAVEL = 14'd9999;
  localparam logic                     RST_ALWAYS_FAR  = 1'b1;

  // Full far move code
  localparam logic signed [CODE_W-1:0] CODE_FULL_FAR = 4'sd7;

endpackage

### rtl/focus_step_planner.sv
// Focus step planner top level: APB register file, move sequencer and the
// shared compare unit used for the nearest step search.
// Depends on fsp_pkg.
//
// Each accepted target (one transaction on the input channel) is turned into
// a run of step commands, one output transaction per command, the final one
// flagged by last_step_o. When the position estimate is unknown, or
// always_far is set, the run opens with a full far move (+7) that sets
// the estimate to full_travel. Each following move passes through the check
// state, the search state (the six step distances, one candidate per cycle
// through a single abs-difference and compare unit) and the move state that
// updates the estimate; the check state holds while a pending command waits
// on the output side. A target that needs no move gives no output
// transaction and frees the block from the check state. in_ready_o is high
// only while the sequencer is idle; the output register lets the last
// command of one request wait while the next target is taken. Configuration
// registers are written through the APB port (pready always high) and must
// only change while the block is idle.
module focus_step_planner #(
  parameter int MAX_MOVES = fsp_pkg::DEFAULT_MAX_MOVES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // APB configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fsp_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [fsp_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [fsp_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready,
  // Target channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [fsp_pkg::POSITION_BITS-1:0]     target_position_i,
  // Step command channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [fsp_pkg::CODE_W-1:0]     step_code_o,
  output logic [fsp_pkg::POSITION_BITS-1:0]     position_after_o,
  output logic                                  last_step_o,
  output logic                                  move_cap_hit_o
);
  import fsp_pkg::*;

  localparam int CNT_W = $clog2(MAX_MOVES + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_MOVE   = 2'd3;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [POSITION_BITS-1:0] dist_q [NUM_STEPS];
  logic [POSITION_BITS-1:0] full_travel_q;
  logic                     always_far_q;
  logic                     cfg_wr;
  logic [REG_IDX_W-1:0]     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q[0]     <= RST_STEP_DIST_1;
      dist_q[1]     <= RST_STEP_DIST_2;
      dist_q[2]     <= RST_STEP_DIST_3;
      dist_q[3]     <= RST_STEP_DIST_4;
      dist_q[4]     <= RST_STEP_DIST_5;
      dist_q[5]     <= RST_STEP_DIST_6;
      full_travel_q <= RST_FULL_TRAVEL;
      always_far_q  <= RST_ALWAYS_FAR;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_DIST_1: dist_q[0]     <= pwdata[POSITION_BITS-1:0];
        REG_STEP_DIST_2: dist_q[1]     <= pwdata[POSITION_BITS-1:0];
        REG_STEP_DIST_3: dist_q[2]     <= pwdata[POSITION_BITS-1:0];
        REG_STEP_DIST_4: dist_q[3]     <= pwdata[POSITION_BITS-1:0];
        REG_STEP_DIST_5: dist_q[4]     <= pwdata[POSITION_BITS-1:0];
        REG_STEP_DIST_6: dist_q[5]     <= pwdata[POSITION_BITS-1:0];
        REG_FULL_TRAVEL: full_travel_q <= pwdata[POSITION_BITS-1:0];
        REG_ALWAYS_FAR:  always_far_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_STEP_DIST_1: prdata[POSITION_BITS-1:0] = dist_q[0];
      REG_STEP_DIST_2: prdata[POSITION_BITS-1:0] = dist_q[1];
      REG_STEP_DIST_3: prdata[POSITION_BITS-1:0] = dist_q[2];
      REG_STEP_DIST_4: prdata[POSITION_BITS-1:0] = dist_q[3];
      REG_STEP_DIST_5: prdata[POSITION_BITS-1:0] = dist_q[4];
      REG_STEP_DIST_6: prdata[POSITION_BITS-1:0] = dist_q[5];
      REG_FULL_TRAVEL: prdata[POSITION_BITS-1:0] = full_travel_q;
      REG_ALWAYS_FAR:  prdata[0]                 = always_far_q;
      default:         prdata                    = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  logic [1:0]                state_q, state_d;
  logic [POSITION_BITS-1:0]  target_q, target_d;
  logic [POSITION_BITS-1:0]  est_q, est_d;
  logic                      known_q, known_d;
  logic [CNT_W-1:0]          n_q, n_d;
  logic [POSITION_BITS-1:0]  gap_q, gap_d;
  logic [STEP_IDX_W-1:0]     sidx_q, sidx_d;
  logic [STEP_IDX_W-1:0]     best_q, best_d;
  logic [POSITION_BITS-1:0]  best_err_q, best_err_d;
  // Pending command: built by a move (or the far move at acceptance), released
  // once the next check knows whether it is the last one.
  logic                      pend_v_q, pend_v_d;
  logic signed [CODE_W-1:0]  pend_code_q, pend_code_d;

  // Output register
  logic                      out_v_q, out_v_d;
  logic signed [CODE_W-1:0]  out_code_q, out_code_d;
  logic [POSITION_BITS-1:0]  out_pos_q, out_pos_d;
  logic                      out_last_q, out_last_d;
  logic                      out_cap_q, out_cap_d;

  // Shared datapath signals
  logic [POSITION_BITS-1:0]  diff_a, diff_b, diff_y;
  logic [POSITION_BITS-1:0]  cand_dist;
  logic [POSITION_BITS-1:0]  best_dist;
  logic [POSITION_BITS:0]    up_sum;
  logic                      in_acc;
  logic                      slot_free;
  logic                      cont;
  logic                      gap_big;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign slot_free  = ~out_v_q | out_ready_i;

  assign cand_dist = dist_q[sidx_q];
  assign best_dist = dist_q[best_q];
  assign up_sum    = {1'b0, est_q} + {1'b0, best_dist};

  // One absolute difference unit, shared: gap in the check cycle,
  // candidate error in the search cycles.
  always_comb begin
    if (state_q == ST_SEARCH) begin
      diff_a = gap_q;
      diff_b = cand_dist;
    end else begin
      diff_a = target_q;
      diff_b = est_q;
    end
    diff_y = (diff_a > diff_b) ? diff_a - diff_b : diff_b - diff_a;
  end

  assign gap_big = (diff_y >= dist_q[0]);
  assign cont    = (n_q < CNT_W'(MAX_MOVES)) & gap_big;

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    est_d       = est_q;
    known_d     = known_q;
    n_d         = n_q;
    gap_d       = gap_q;
    sidx_d      = sidx_q;
    best_d      = best_q;
    best_err_d  = best_err_q;
    pend_v_d    = pend_v_q;
    pend_code_d = pend_code_q;
    out_v_d     = out_v_q;
    out_code_d  = out_code_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_cap_d   = out_cap_q;

    // Drop the output transaction once taken
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // Saturate the target to the travel limit
          target_d = (target_position_i > full_travel_q) ? full_travel_q
                                                         : target_position_i;
          n_d      = '0;
          pend_v_d = 1'b0;
          if (!known_q || always_far_q) begin
            est_d       = full_travel_q;
            known_d     = 1'b1;
            pend_v_d    = 1'b1;
            pend_code_d = CODE_FULL_FAR;
            n_d         = CNT_W'(1);
          end
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        // Hold while a pending command cannot reach the output register
        if (!pend_v_q || slot_free) begin
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_code_d = pend_code_q;
            out_pos_d  = est_q;
            out_last_d = ~cont;
            out_cap_d  = ~cont & gap_big;
            pend_v_d   = 1'b0;
          end
          if (cont) begin
            gap_d   = diff_y;
            sidx_d  = '0;
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_SEARCH: begin
        // Strict less-than keeps the smaller code on a tie
        if (sidx_q == '0 || diff_y < best_err_q) begin
          best_d     = sidx_q;
          best_err_d = diff_y;
        end
        if (sidx_q == STEP_IDX_W'(NUM_STEPS - 1)) begin
          state_d = ST_MOVE;
        end else begin
          sidx_d = sidx_q + STEP_IDX_W'(1);
        end
      end

      ST_MOVE: begin
        // Move toward the target, clamp to 0..travel
        if (target_q < est_q) begin
          est_d       = (best_dist > est_q) ? '0 : est_q - best_dist;
          pend_code_d = -$signed({1'b0, best_q} + CODE_W'(1));
        end else begin
          est_d       = (up_sum > {1'b0, full_travel_q}) ? full_travel_q
                                                         : up_sum[POSITION_BITS-1:0];
          pend_code_d = $signed({1'b0, best_q} + CODE_W'(1));
        end
        pend_v_d = 1'b1;
        n_d      = n_q + CNT_W'(1);
        state_d  = ST_CHECK;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      est_q    <= '0;
      known_q  <= 1'b0;
      n_q      <= '0;
      sidx_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      est_q    <= est_d;
      known_q  <= known_d;
      n_q      <= n_d;
      sidx_q   <= sidx_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    target_q    <= target_d;
    gap_q       <= gap_d;
    best_q      <= best_d;
    best_err_q  <= best_err_d;
    pend_code_q <= pend_code_d;
    out_code_q  <= out_code_d;
    out_pos_q   <= out_pos_d;
    out_last_q  <= out_last_d;
    out_cap_q   <= out_cap_d;
  end

  assign out_valid_o      = out_v_q;
  assign step_code_o      = out_code_q;
  assign position_after_o = out_pos_q;
  assign last_step_o      = out_last_q;
  assign move_cap_hit_o   = out_cap_q;

`ifndef SYNTH
  a_cap_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_cap_q |-> out_last_q)
    else $error("move cap flag without last step");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(MAX_MOVES))
    else $error("move count beyond cap");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_v_q)
    else $error("pending command left behind at idle");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_CHECK)
    else $error("accepted target did not start a check");
`endif

endmodule

### verif/focus_step_planner_tb.sv
// Self-checking testbench for the focus step planner: drives targets and APB
// register writes, predicts every step command and checks the output channel.
// Depends on fsp_pkg and the focus_step_planner RTL.
module focus_step_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsp_pkg::*;

  localparam int MaxMoves     = DEFAULT_MAX_MOVES;
  localparam int PosMax       = (1 << POSITION_BITS) - 1;
  localparam int QuietLimit   = 4000;  // cycles without any transaction
  localparam int LongHold     = 400;   // receiver hold-off for back-pressure
  localparam int SettleCycles = 16;    // lets a target with no move free the block
  localparam int TailCycles   = 8 * MaxMoves + 2;

  typedef struct packed {
    logic signed [CODE_W-1:0] code;
    logic [POSITION_BITS-1:0] pos;
    logic                     last;
    logic                     cap;
  } step_cmd_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0]    pwdata = '0;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [POSITION_BITS-1:0] target_position_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [CODE_W-1:0] step_code_o;
  logic [POSITION_BITS-1:0] position_after_o;
  logic                     last_step_o;
  logic                     move_cap_hit_o;

  focus_step_planner #(
    .MAX_MOVES(MaxMoves)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .target_position_i(target_position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .step_code_o      (step_code_o),
    .position_after_o (position_after_o),
    .last_step_o      (last_step_o),
    .move_cap_hit_o   (move_cap_hit_o)
  );

  // Lens model: configuration copy plus the position estimate it tracks.
  int dist_tab [1:NUM_STEPS];
  int travel_cfg;
  bit far_cfg;
  int lens_pos;
  bit lens_known;

  // Opening targets under the reset configuration
  int reset_targets [8] = '{0, PosMax, 9999, 10000, 1, 8191, 5000, 37};

  step_cmd_t                steps_due[$];       // step commands still to arrive
  logic [POSITION_BITS-1:0] targets_pending[$]; // targets not yet offered
  int targets_queued = 0;
  int targets_taken  = 0;
  int fail_count     = 0;
  bit sender_gaps    = 1'b0;
  bit receiver_gaps  = 1'b0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int send_gap       = 0;
  int rcv_hold       = 0;
  int quiet_cycles   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_to(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Pick the step code whose distance lies nearest the gap; the smaller code
  // wins a tie because only a strictly better error replaces the best.
  function automatic int closest_code(int gap);
    int best;
    int best_err;
    best     = 1;
    best_err = gap_to(gap, dist_tab[1]);
    for (int k = 2; k <= NUM_STEPS; k++) begin
      if (gap_to(gap, dist_tab[k]) < best_err) begin
        best     = k;
        best_err = gap_to(gap, dist_tab[k]);
      end
    end
    return best;
  endfunction

  // Work out the whole run of step commands for one accepted target and
  // append it to the expected queue, advancing the lens model as it goes.
  function automatic void plan_moves(logic [POSITION_BITS-1:0] raw);
    step_cmd_t run [MaxMoves];
    int        n;
    int        tgt;
    int        code;
    n   = 0;
    tgt = raw;
    if (tgt > travel_cfg) tgt = travel_cfg;
    // Unknown position or forced re-home: open with the full far move
    if (!lens_known || far_cfg) begin
      lens_pos   = travel_cfg;
      lens_known = 1'b1;
      run[n]     = '{code: CODE_FULL_FAR, pos: POSITION_BITS'(lens_pos), last: 1'b0,
                     cap: 1'b0};
      n++;
    end
    while (n < MaxMoves && gap_to(tgt, lens_pos) >= dist_tab[1]) begin
      code = closest_code(gap_to(tgt, lens_pos));
      if (tgt < lens_pos) begin
        // Move closer; clamp at zero
        lens_pos = (dist_tab[code] > lens_pos) ? 0 : lens_pos - dist_tab[code];
        code     = -code;
      end else begin
        // Move farther; clamp at the travel limit
        lens_pos = (lens_pos + dist_tab[code] > travel_cfg) ? travel_cfg
                                                             : lens_pos + dist_tab[code];
      end
      run[n] = '{code: CODE_W'(code), pos: POSITION_BITS'(lens_pos), last: 1'b0, cap: 1'b0};
      n++;
    end
    if (n > 0) begin
      run[n-1].last = 1'b1;
      run[n-1].cap  = (gap_to(tgt, lens_pos) >= dist_tab[1]);
    end
    for (int i = 0; i < n; i++) steps_due.push_back(run[i]);
  endfunction

  // Compare one step command transaction with the oldest expectation.
  function automatic void check_step();
    step_cmd_t want;
    if (steps_due.size() == 0) begin
      $error("step command with nothing expected: code %0d position %0d",
             step_code_o, position_after_o);
      fail_count++;
      return;
    end
    want = steps_due.pop_front();
    if (step_code_o !== want.code) begin
      $error("step_code: expected %0d, got %0d", want.code, step_code_o);
      fail_count++;
    end
    if (position_after_o !== want.pos) begin
      $error("position_after: expected %0d, got %0d", want.pos, position_after_o);
      fail_count++;
    end
    if (last_step_o !== want.last) begin
      $error("last_step: expected %0b, got %0b", want.last, last_step_o);
      fail_count++;
    end
    if (move_cap_hit_o !== want.cap) begin
      $error("move_cap_hit: expected %0b, got %0b", want.cap, move_cap_hit_o);
      fail_count++;
    end
  endfunction

  // Idle length: busy_pct percent of the calls idle, one in ten of those long.
  function automatic int pick_gap(bit enabled, int busy_pct);
    if (!enabled || $urandom_range(0, 99) >= busy_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 3);
  endfunction

  // Target driver: hold valid and payload until the transaction completes,
  // then either idle for the chosen gap or offer the next pending target.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        plan_moves(target_position_i);
        targets_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (targets_pending.size() > 0) begin
          in_valid_i        <= 1'b1;
          target_position_i <= targets_pending.pop_front();
          send_gap = pick_gap(sender_gaps, 45);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Step command monitor: check each transaction, then decide the next ready.
  // A requested long hold-off is counted here so the block backs up fully.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_step();
      if (holds_served < hold_requests) begin
        holds_served++;
        rcv_hold = LongHold;
      end
      if (rcv_hold == 0) rcv_hold = pick_gap(receiver_gaps, 30);
      if (rcv_hold > 0) begin
        rcv_hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge that ends the access. Junk above the register width is masked.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom_range(0, 1) ? APB_DATA_W'($urandom()) : '0;
    if (idx == REG_ALWAYS_FAR) word[0] = value[0];
    else word[POSITION_BITS-1:0] = value[POSITION_BITS-1:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FULL_TRAVEL: travel_cfg = word[POSITION_BITS-1:0];
      REG_ALWAYS_FAR:  far_cfg    = word[0];
      default:         dist_tab[int'(idx) + 1] = word[POSITION_BITS-1:0];
    endcase
  endtask

  task automatic set_config(int d1, int d2, int d3, int d4, int d5, int d6,
                            int travel, bit far);
    write_reg(REG_STEP_DIST_1, d1);
    write_reg(REG_STEP_DIST_2, d2);
    write_reg(REG_STEP_DIST_3, d3);
    write_reg(REG_STEP_DIST_4, d4);
    write_reg(REG_STEP_DIST_5, d5);
    write_reg(REG_STEP_DIST_6, d6);
    write_reg(REG_FULL_TRAVEL, travel);
    write_reg(REG_ALWAYS_FAR, far);
  endtask

  function automatic int random_distance();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 1;
    if (r < 16) return PosMax;
    if (r < 40) return $urandom_range(1, 64);
    return $urandom_range(1, 4000);
  endfunction

  task automatic random_config();
    int r;
    int travel;
    r      = $urandom_range(0, 99);
    travel = (r < 15) ? PosMax : (r < 25) ? $urandom_range(1, 200)
                                          : $urandom_range(2000, PosMax);
    set_config(random_distance(), random_distance(), random_distance(),
               random_distance(), random_distance(), random_distance(),
               travel, $urandom_range(0, 99) < 40);
  endtask

  function automatic logic [POSITION_BITS-1:0] random_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return POSITION_BITS'(PosMax);
    if (r < 30) return POSITION_BITS'(travel_cfg);
    if (r < 45) return POSITION_BITS'($urandom_range(0, PosMax));
    return POSITION_BITS'($urandom_range(0, travel_cfg));
  endfunction

  function automatic void queue_target(int tgt);
    targets_pending.push_back(POSITION_BITS'(tgt));
    targets_queued++;
  endfunction

  // Hold the sender until every target is taken and every command has come,
  // then let the block finish any target that needed no move.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (targets_taken != targets_queued || steps_due.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    dist_tab[1] = RST_STEP_DIST_1;
    dist_tab[2] = RST_STEP_DIST_2;
    dist_tab[3] = RST_STEP_DIST_3;
    dist_tab[4] = RST_STEP_DIST_4;
    dist_tab[5] = RST_STEP_DIST_5;
    dist_tab[6] = RST_STEP_DIST_6;
    travel_cfg  = RST_FULL_TRAVEL;
    far_cfg     = RST_ALWAYS_FAR;
    lens_pos    = 0;
    lens_known  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: unknown position first, saturated targets,
    // a full far move on every request.
    foreach (reset_targets[i])
      queue_target(reset_targets[i]);
    wait_idle();

    // Keep the estimate: no move needed, a gap just under and exactly at
    // the tolerance.
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    set_config(RST_STEP_DIST_1, RST_STEP_DIST_2, RST_STEP_DIST_3, RST_STEP_DIST_4,
               RST_STEP_DIST_5, RST_STEP_DIST_6, RST_FULL_TRAVEL, 1'b0);
    queue_target(lens_pos);
    wait_idle();
    queue_target(lens_pos > 37 ? lens_pos - 37 : lens_pos + 37);
    queue_target(PosMax);
    wait_idle();
    queue_target(lens_pos - 38);
    wait_idle();

    // Tiny steps: the run stops at the move cap, far move counted.
    set_config(1, 2, 3, 4, 5, 6, PosMax, 1'b1);
    queue_target(0);
    queue_target(PosMax);
    queue_target(8000);
    wait_idle();

    // Zero tolerance never converges.
    set_config(0, 96, 244, 617, 1562, 3952, 9999, 1'b0);
    queue_target(5000);
    queue_target(5000);
    wait_idle();

    // Largest distances with the smallest travel.
    set_config(PosMax, PosMax, PosMax, PosMax, PosMax, PosMax, 1, 1'b0);
    queue_target(0);
    queue_target(PosMax);
    queue_target(1);
    wait_idle();

    // All distances equal: every search ties and code 1 wins.
    set_config(PosMax, PosMax, PosMax, PosMax, PosMax, PosMax, PosMax, 1'b1);
    queue_target(0);
    queue_target(1);
    wait_idle();

    // Equal distances and a gap halfway between two of them.
    set_config(40, 100, 100, 300, 500, PosMax, 2000, 1'b0);
    queue_target(0);
    wait_idle();
    queue_target(lens_pos + 200);
    queue_target(2000);
    wait_idle();

    // Random part: a fresh configuration per phase, idling varied, and a
    // long receiver hold-off while the sender keeps offering targets.
    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      sender_gaps   = (phase % 3 != 1);
      receiver_gaps = (phase % 2 == 0);
      if (phase % 5 == 1) hold_requests++;
      repeat (30) queue_target(random_target());
      wait_idle();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/fsp_pkg.sv
rtl/focus_step_planner.sv
verif/focus_step_planner_tb.sv
